### hdl/erld_pkg.sv
// Shared types and codes for the extent run-list decoder.
`default_nettype none

package erld_pkg;

  // End cause codes reported with each result.
  localparam logic [2:0] CAUSE_RUNNING  = 3'd0;
  localparam logic [2:0] CAUSE_ZERO_HDR = 3'd1;
  localparam logic [2:0] CAUSE_ZERO_LEN = 3'd2;
  localparam logic [2:0] CAUSE_PAST_END = 3'd3;
  localparam logic [2:0] CAUSE_BUDGET   = 3'd4;
  localparam logic [2:0] CAUSE_OVERSIZE = 3'd5;

  // Event queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One event from the front: a finished run or an end of list.
  typedef struct packed {
    logic        is_run;
    logic [2:0]  cause;
    logic        restart;
    logic [63:0] restart_vcn;
    logic [63:0] length;
    logic [63:0] delta;
  } ev_t;

endpackage

`default_nettype wire

### hdl/erld_front.sv
// Front end: accepts run-list bytes, parses headers and fields, posts events.
`default_nettype none

module erld_front #(
  parameter int LIST_WINDOW_BYTES = 512
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_fire,
  input  wire logic [7:0]   list_byte,
  input  wire logic         list_start,
  input  wire logic [63:0]  first_vcn,
  input  wire logic [8:0]   list_offset,
  output erld_pkg::ev_t     ev,
  output logic              ev_push
);

  localparam int CW_RAW = $clog2(LIST_WINDOW_BYTES + 32);
  localparam int CW     = (CW_RAW > 10) ? CW_RAW : 10;
  localparam logic [CW-1:0] WINDOW = CW'(LIST_WINDOW_BYTES);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_LENGTH = 2'd1;
  localparam logic [1:0] PH_OFFSET = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  logic [1:0]    phase, phase_next;
  logic [3:0]    len_left, len_left_next;
  logic [3:0]    off_left, off_left_next;
  logic [3:0]    len_size, len_size_next;
  logic [3:0]    off_size, off_size_next;
  logic [63:0]   len_accum, len_accum_next;
  logic [63:0]   delta_accum, delta_accum_next;
  logic [CW-1:0] count, count_next;
  logic          pend_restart, pend_restart_next;
  logic [63:0]   restart_vcn, restart_vcn_next;

  logic [CW-1:0] offset_ext;
  logic [CW-1:0] budget;
  logic [3:0]    len_nib, off_nib;
  logic [2:0]    len_idx, off_idx;
  logic [63:0]   len_shift, off_shift;
  logic [63:0]   delta_raw, delta_ext;

  assign offset_ext = CW'(list_offset);
  assign budget     = (offset_ext < WINDOW) ? (WINDOW - offset_ext) : '0;
  assign len_nib    = list_byte[3:0];
  assign off_nib    = list_byte[7:4];
  assign len_idx    = 3'(len_size - len_left);
  assign off_idx    = 3'(off_size - off_left);
  assign len_shift  = {56'd0, list_byte} << {len_idx, 3'b000};
  assign off_shift  = {56'd0, list_byte} << {off_idx, 3'b000};
  assign delta_raw  = delta_accum | off_shift;

  // Sign-extend the delta from its own field width.
  always_comb begin
    delta_ext = delta_raw;
    case (off_size)
      4'd1: delta_ext = {{56{delta_raw[7]}},  delta_raw[7:0]};
      4'd2: delta_ext = {{48{delta_raw[15]}}, delta_raw[15:0]};
      4'd3: delta_ext = {{40{delta_raw[23]}}, delta_raw[23:0]};
      4'd4: delta_ext = {{32{delta_raw[31]}}, delta_raw[31:0]};
      4'd5: delta_ext = {{24{delta_raw[39]}}, delta_raw[39:0]};
      4'd6: delta_ext = {{16{delta_raw[47]}}, delta_raw[47:0]};
      4'd7: delta_ext = {{8{delta_raw[55]}},  delta_raw[55:0]};
      default: delta_ext = delta_raw;
    endcase
  end

  always_comb begin
    phase_next        = phase;
    len_left_next     = len_left;
    off_left_next     = off_left;
    len_size_next     = len_size;
    off_size_next     = off_size;
    len_accum_next    = len_accum;
    delta_accum_next  = delta_accum;
    count_next        = count;
    pend_restart_next = pend_restart;
    restart_vcn_next  = restart_vcn;
    ev_push           = 1'b0;
    ev                = '0;

    if (in_fire) begin
      if (list_start) begin
        phase_next        = PH_HEADER;
        count_next        = '0;
        pend_restart_next = 1'b1;
        restart_vcn_next  = first_vcn;
        len_left_next     = '0;
        off_left_next     = '0;
        len_size_next     = '0;
        off_size_next     = '0;
        len_accum_next    = '0;
        delta_accum_next  = '0;
      end
      ev.restart     = pend_restart_next;
      ev.restart_vcn = restart_vcn_next;

      unique case (phase_next)
        PH_HEADER: begin
          if (count_next >= budget) begin
            phase_next = PH_DONE;
            ev_push    = 1'b1;
            ev.cause   = erld_pkg::CAUSE_BUDGET;
          end else begin
            count_next = count_next + 1'b1;
            if (list_byte == 8'd0) begin
              phase_next = PH_DONE;
              ev_push    = 1'b1;
              ev.cause   = erld_pkg::CAUSE_ZERO_HDR;
            end else if (len_nib == 4'd0) begin
              phase_next = PH_DONE;
              ev_push    = 1'b1;
              ev.cause   = erld_pkg::CAUSE_ZERO_LEN;
            end else if (len_nib > 4'd8 || off_nib > 4'd8) begin
              phase_next = PH_DONE;
              ev_push    = 1'b1;
              ev.cause   = erld_pkg::CAUSE_OVERSIZE;
            end else begin
              len_size_next    = len_nib;
              off_size_next    = off_nib;
              len_left_next    = len_nib;
              off_left_next    = off_nib;
              len_accum_next   = '0;
              delta_accum_next = '0;
              phase_next       = PH_LENGTH;
            end
          end
        end
        PH_LENGTH: begin
          count_next     = count_next + 1'b1;
          len_accum_next = len_accum | len_shift;
          len_left_next  = len_left - 1'b1;
          if (len_left_next == 4'd0) begin
            if (off_left == 4'd0) begin
              // No offset field: the run keeps the current physical cluster.
              phase_next = PH_HEADER;
              ev_push    = 1'b1;
              ev.is_run  = 1'b1;
              ev.cause   = erld_pkg::CAUSE_RUNNING;
              ev.length  = len_accum_next;
              ev.delta   = '0;
            end else begin
              phase_next = PH_OFFSET;
            end
          end
        end
        PH_OFFSET: begin
          count_next       = count_next + 1'b1;
          delta_accum_next = delta_raw;
          off_left_next    = off_left - 1'b1;
          if (off_left_next == 4'd0) begin
            phase_next = PH_HEADER;
            ev_push    = 1'b1;
            ev.is_run  = 1'b1;
            ev.cause   = erld_pkg::CAUSE_RUNNING;
            ev.length  = len_accum;
            ev.delta   = delta_ext;
          end
        end
        PH_DONE: begin
          // Drop bytes until the next list start.
        end
        default: begin
        end
      endcase

      if (ev_push) begin
        pend_restart_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      len_left     <= '0;
      off_left     <= '0;
      len_size     <= '0;
      off_size     <= '0;
      count        <= '0;
      pend_restart <= 1'b0;
    end else begin
      phase        <= phase_next;
      len_left     <= len_left_next;
      off_left     <= off_left_next;
      len_size     <= len_size_next;
      off_size     <= off_size_next;
      count        <= count_next;
      pend_restart <= pend_restart_next;
    end
    len_accum   <= len_accum_next;
    delta_accum <= delta_accum_next;
    restart_vcn <= restart_vcn_next;
  end

endmodule

`default_nettype wire

### hdl/erld_queue.sv
// Short event queue between the decoder front and back.
`default_nettype none

module erld_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire erld_pkg::ev_t push_ev,
  output logic               full,
  input  wire logic          pop,
  output erld_pkg::ev_t      head_ev,
  output logic               not_empty
);

  localparam logic [erld_pkg::QPTR_W:0] DEPTH_CNT =
    (erld_pkg::QPTR_W + 1)'(erld_pkg::QUEUE_DEPTH);
  localparam logic [erld_pkg::QPTR_W-1:0] LAST_PTR =
    erld_pkg::QPTR_W'(erld_pkg::QUEUE_DEPTH - 1);

  erld_pkg::ev_t                slots [erld_pkg::QUEUE_DEPTH];
  logic [erld_pkg::QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [erld_pkg::QPTR_W:0]    used;
  logic                         do_push, do_pop;

  assign full      = (used == DEPTH_CNT);
  assign not_empty = (used != '0);
  assign head_ev   = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        used <= used + 1'b1;
      end else if (do_pop && !do_push) begin
        used <= used - 1'b1;
      end
    end
    if (do_push) begin
      slots[wr_ptr] <= push_ev;
    end
  end

endmodule

`default_nettype wire

### hdl/erld_back.sv
// Back end: applies events to the cluster counters and drives the result register.
`default_nettype none

module erld_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          ev_valid,
  input  wire erld_pkg::ev_t ev,
  output logic               ev_pop,
  input  wire logic [63:0]   last_vcn,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               run_valid,
  output logic [63:0]        run_vcn,
  output logic [63:0]        run_lcn,
  output logic [63:0]        run_clusters,
  output logic               list_done,
  output logic [2:0]         end_cause,
  output logic               any_runs
);

  logic [63:0] cur_vcn, cur_lcn;
  logic        done, seen;

  logic [63:0] vcn_base, lcn_base, lcn_sum, vcn_end;
  logic        done_base, seen_base, past_end, emit;

  assign ev_pop    = ev_valid && (!out_valid || out_ready);
  assign vcn_base  = ev.restart ? ev.restart_vcn : cur_vcn;
  assign lcn_base  = ev.restart ? 64'd0 : cur_lcn;
  assign done_base = ev.restart ? 1'b0 : done;
  assign seen_base = ev.restart ? 1'b0 : seen;
  assign lcn_sum   = lcn_base + ev.delta;
  assign vcn_end   = vcn_base + ev.length;
  assign past_end  = $signed(vcn_end) > $signed(last_vcn);
  // Events behind a finished list are dropped until the next restart.
  assign emit      = !done_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_vcn   <= '0;
      cur_lcn   <= '0;
      done      <= 1'b0;
      seen      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ev_pop && emit) begin
        out_valid <= 1'b1;
        if (ev.is_run) begin
          cur_vcn <= vcn_end;
          cur_lcn <= lcn_sum;
          seen    <= 1'b1;
          done    <= past_end;
        end else begin
          cur_vcn <= vcn_base;
          cur_lcn <= lcn_base;
          seen    <= seen_base;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev_pop && emit) begin
      if (ev.is_run) begin
        run_valid    <= 1'b1;
        run_vcn      <= vcn_base;
        run_lcn      <= lcn_sum;
        run_clusters <= ev.length;
        list_done    <= past_end;
        end_cause    <= past_end ? erld_pkg::CAUSE_PAST_END : erld_pkg::CAUSE_RUNNING;
        any_runs     <= 1'b1;
      end else begin
        run_valid    <= 1'b0;
        run_vcn      <= '0;
        run_lcn      <= '0;
        run_clusters <= '0;
        list_done    <= 1'b1;
        end_cause    <= ev.cause;
        any_runs     <= seen_base;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/extent_run_list_decoder_top.sv
// Top level of the extent run-list decoder: register port, front, queue and back.
`default_nettype none

// Decodes a mapping-pair run list streamed one byte per item on the input
// channel and reports, per finished run, its start virtual cluster, start
// physical cluster (running sum of the sign-extended deltas) and length, plus
// one closing result when the list ends (zero header, zero length nibble,
// run end past last_vcn, byte budget spent, or a field size above 8). Raise
// list_start with the first header byte of each list; first_vcn is sampled
// then, while last_vcn and list_offset apply as written. A byte budget of
// LIST_WINDOW_BYTES minus list_offset is checked at each header. Throughput
// is one byte per clock: the front parses a byte per cycle, a two-entry event
// queue decouples it from the back, and the back does two 64-bit adds and a
// signed compare per event into an output register, so a stalled result only
// stops input once the queue fills. A run's event is held in the queue, then
// popped into the output register. Registers sit at byte addresses 0
// (first_vcn), 8 (last_vcn) and 16 (list_offset) on a 64-bit APB port.
module extent_run_list_decoder_top #(
  parameter int LIST_WINDOW_BYTES = 512
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [63:0]        pwdata,
  output logic [63:0]             prdata,
  output logic                    pready,
  // byte input
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         list_byte,
  input  wire logic               list_start,
  // result output
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    run_valid,
  output logic signed [63:0]      run_vcn,
  output logic signed [63:0]      run_lcn,
  output logic signed [63:0]      run_clusters,
  output logic                    list_done,
  output logic [2:0]              end_cause,
  output logic                    any_runs
);

  localparam logic [1:0] REG_FIRST_VCN   = 2'd0;
  localparam logic [1:0] REG_LAST_VCN    = 2'd1;
  localparam logic [1:0] REG_LIST_OFFSET = 2'd2;

  logic [63:0] first_vcn, last_vcn;
  logic [8:0]  list_offset;
  logic        cfg_write;

  erld_pkg::ev_t front_ev, head_ev;
  logic          front_push, queue_full, queue_has, back_pop;
  logic          in_fire;

  logic [63:0] vcn_q, lcn_q, clusters_q;

  // Register write on the access phase; no wait states.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_vcn   <= 64'd0;
      last_vcn    <= 64'd0;
      list_offset <= 9'd64;
    end else if (cfg_write) begin
      unique case (paddr[4:3])
        REG_FIRST_VCN:   first_vcn   <= pwdata;
        REG_LAST_VCN:    last_vcn    <= pwdata;
        REG_LIST_OFFSET: list_offset <= pwdata[8:0];
        default: begin
          // Unmapped address: drop the write.
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_FIRST_VCN:   prdata = first_vcn;
      REG_LAST_VCN:    prdata = last_vcn;
      REG_LIST_OFFSET: prdata = {55'd0, list_offset};
      default:         prdata = 64'd0;
    endcase
  end

  // Accept a byte whenever the queue has room for the event it may post.
  assign in_ready = !queue_full;
  assign in_fire  = in_valid && in_ready;

  erld_front #(
    .LIST_WINDOW_BYTES (LIST_WINDOW_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_fire     (in_fire),
    .list_byte   (list_byte),
    .list_start  (list_start),
    .first_vcn   (first_vcn),
    .list_offset (list_offset),
    .ev          (front_ev),
    .ev_push     (front_push)
  );

  erld_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_push),
    .push_ev   (front_ev),
    .full      (queue_full),
    .pop       (back_pop),
    .head_ev   (head_ev),
    .not_empty (queue_has)
  );

  erld_back u_back (
    .clk          (clk),
    .rst          (rst),
    .ev_valid     (queue_has),
    .ev           (head_ev),
    .ev_pop       (back_pop),
    .last_vcn     (last_vcn),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .run_valid    (run_valid),
    .run_vcn      (vcn_q),
    .run_lcn      (lcn_q),
    .run_clusters (clusters_q),
    .list_done    (list_done),
    .end_cause    (end_cause),
    .any_runs     (any_runs)
  );

  assign run_vcn      = $signed(vcn_q);
  assign run_lcn      = $signed(lcn_q);
  assign run_clusters = $signed(clusters_q);

endmodule

`default_nettype wire

### verif/run_list_checker.sv
// Checker for the extent run-list decoder: predicts every result and compares it.
module run_list_checker #(
  parameter int         WINDOW_BYTES     = 512,
  parameter logic [4:0] FIRST_VCN_ADDR   = 5'd0,
  parameter logic [4:0] LAST_VCN_ADDR    = 5'd8,
  parameter logic [4:0] LIST_OFFSET_ADDR = 5'd16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  list_byte,
  input  logic        list_start,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        run_valid,
  input  logic [63:0] run_vcn,
  input  logic [63:0] run_lcn,
  input  logic [63:0] run_clusters,
  input  logic        list_done,
  input  logic [2:0]  end_cause,
  input  logic        any_runs,
  output int          open_runs,
  output int          fail_count
);

  typedef enum logic [1:0] {AWAIT_HEADER, IN_LENGTH, IN_OFFSET, LIST_ENDED} parse_phase_t;

  typedef struct packed {
    logic        run_valid;
    logic [63:0] vcn;
    logic [63:0] lcn;
    logic [63:0] clusters;
    logic        done;
    logic [2:0]  cause;
    logic        has_runs;
  } decode_result_t;

  // register shadows
  logic [63:0] cfg_first_vcn, cfg_last_vcn;
  logic [8:0]  cfg_list_offset;

  // decoder state
  parse_phase_t phase;
  logic [3:0]   len_left, ofs_left, len_size, ofs_size;
  logic [63:0]  len_acc, delta_acc, next_vcn, next_lcn;
  int unsigned  consumed;
  logic         seen;

  decode_result_t runs_due[$];
  int errs;

  task automatic clear_list();
    len_left  = '0;
    ofs_left  = '0;
    len_size  = '0;
    ofs_size  = '0;
    len_acc   = '0;
    delta_acc = '0;
    next_lcn  = '0;
    consumed  = 0;
    seen      = 1'b0;
    phase     = AWAIT_HEADER;
  endtask

  task automatic finish_list(input logic [2:0] cause);
    decode_result_t r;
    r = '0;
    r.done     = 1'b1;
    r.cause    = cause;
    r.has_runs = seen;
    phase = LIST_ENDED;
    runs_due.insert(runs_due.size(), r);
  endtask

  task automatic close_run();
    decode_result_t r;
    logic [63:0] delta;
    int bits;
    delta = delta_acc;
    bits  = 8 * int'(ofs_size);
    // sign-extend short deltas from their own width
    if (ofs_size > 0 && ofs_size < 8 && delta_acc[bits-1])
      delta = delta | ({64{1'b1}} << bits);
    r = '0;
    r.run_valid = 1'b1;
    r.vcn       = next_vcn;
    next_lcn    = next_lcn + delta;
    r.lcn       = next_lcn;
    r.clusters  = len_acc;
    next_vcn    = next_vcn + len_acc;
    seen        = 1'b1;
    r.has_runs  = 1'b1;
    if ($signed(next_vcn) > $signed(cfg_last_vcn)) begin
      r.done  = 1'b1;
      r.cause = erld_pkg::CAUSE_PAST_END;
      phase   = LIST_ENDED;
    end else begin
      r.cause = erld_pkg::CAUSE_RUNNING;
      phase   = AWAIT_HEADER;
    end
    runs_due.insert(runs_due.size(), r);
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic first);
    int unsigned budget;
    int idx;
    if (first) begin
      clear_list();
      next_vcn = cfg_first_vcn;
    end
    budget = (int'(cfg_list_offset) < WINDOW_BYTES) ? WINDOW_BYTES - int'(cfg_list_offset) : 0;
    case (phase)
      AWAIT_HEADER: begin
        if (consumed >= budget) begin
          finish_list(erld_pkg::CAUSE_BUDGET);
        end else begin
          if (consumed < 65535) consumed++;
          if (b == 8'h00) finish_list(erld_pkg::CAUSE_ZERO_HDR);
          else if (b[3:0] == 4'h0) finish_list(erld_pkg::CAUSE_ZERO_LEN);
          else if (b[3:0] > 4'd8 || b[7:4] > 4'd8) finish_list(erld_pkg::CAUSE_OVERSIZE);
          else begin
            len_size  = b[3:0];
            ofs_size  = b[7:4];
            len_left  = b[3:0];
            ofs_left  = b[7:4];
            len_acc   = '0;
            delta_acc = '0;
            phase     = IN_LENGTH;
          end
        end
      end
      IN_LENGTH: begin
        if (consumed < 65535) consumed++;
        idx = int'(len_size - len_left) & 7;
        len_acc = len_acc | (64'(b) << (8 * idx));
        len_left--;
        if (len_left == 0) begin
          if (ofs_left == 0) close_run();
          else phase = IN_OFFSET;
        end
      end
      IN_OFFSET: begin
        if (consumed < 65535) consumed++;
        idx = int'(ofs_size - ofs_left) & 7;
        delta_acc = delta_acc | (64'(b) << (8 * idx));
        ofs_left--;
        if (ofs_left == 0) close_run();
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    decode_result_t want;
    if (rst) begin
      cfg_first_vcn   = '0;
      cfg_last_vcn    = '0;
      cfg_list_offset = 9'd64;
      clear_list();
      next_vcn = '0;
      runs_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (runs_due.size() == 0) begin
          $error("result arrived with nothing outstanding");
          errs++;
        end else begin
          want = runs_due.pop_front();
          check_field("run_valid", 64'(want.run_valid), 64'(run_valid));
          check_field("run_vcn", want.vcn, run_vcn);
          check_field("run_lcn", want.lcn, run_lcn);
          check_field("run_clusters", want.clusters, run_clusters);
          check_field("list_done", 64'(want.done), 64'(list_done));
          check_field("end_cause", 64'(want.cause), 64'(end_cause));
          check_field("any_runs", 64'(want.has_runs), 64'(any_runs));
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          FIRST_VCN_ADDR:   cfg_first_vcn   = pwdata;
          LAST_VCN_ADDR:    cfg_last_vcn    = pwdata;
          LIST_OFFSET_ADDR: cfg_list_offset = pwdata[8:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) decode_byte(list_byte, list_start);
    end
    open_runs  = runs_due.size();
    fail_count = errs;
  end

  initial errs = 0;

endmodule

### verif/testbench.sv
// Top of the decoder testbench: clock, reset, stimulus, result sink and verdict.
module testbench;

  localparam int         WINDOW_BYTES     = 512;
  localparam logic [4:0] FIRST_VCN_ADDR   = 5'd0;
  localparam logic [4:0] LAST_VCN_ADDR    = 5'd8;
  localparam logic [4:0] LIST_OFFSET_ADDR = 5'd16;
  localparam logic [63:0] VCN_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] VCN_MIN = 64'h8000_0000_0000_0000;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int WATCHDOG_LIMIT   = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  list_byte = '0;
  logic        list_start = 1'b0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        run_valid, list_done, any_runs;
  logic [63:0] run_vcn, run_lcn, run_clusters;
  logic [2:0]  end_cause;

  int open_runs, fail_count;

  // stimulus knobs, changed per phase
  logic tx_jitter = 1'b1;
  logic rx_jitter = 1'b1;
  logic hold_request = 1'b0;
  int   bytes_sent = 0;

  always #2 clk = ~clk;

  extent_run_list_decoder_top #(.LIST_WINDOW_BYTES(WINDOW_BYTES)) uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .list_byte(list_byte), .list_start(list_start),
    .out_valid(out_valid), .out_ready(out_ready),
    .run_valid(run_valid), .run_vcn(run_vcn), .run_lcn(run_lcn),
    .run_clusters(run_clusters), .list_done(list_done),
    .end_cause(end_cause), .any_runs(any_runs)
  );

  run_list_checker #(
    .WINDOW_BYTES(WINDOW_BYTES),
    .FIRST_VCN_ADDR(FIRST_VCN_ADDR),
    .LAST_VCN_ADDR(LAST_VCN_ADDR),
    .LIST_OFFSET_ADDR(LIST_OFFSET_ADDR)
  ) run_check (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .list_byte(list_byte), .list_start(list_start),
    .out_valid(out_valid), .out_ready(out_ready),
    .run_valid(run_valid), .run_vcn(run_vcn), .run_lcn(run_lcn),
    .run_clusters(run_clusters), .list_done(list_done),
    .end_cause(end_cause), .any_runs(any_runs),
    .open_runs(open_runs), .fail_count(fail_count)
  );

  // Offer one item, maybe after an idle gap, and hold it until accepted.
  // Valid stays high on return; the caller either offers the next item or drops it
  // in the same step.
  task automatic send_byte(input logic [7:0] value, input logic first);
    int gap;
    gap = 0;
    if (tx_jitter && $urandom_range(0, 99) < 30)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    list_byte  <= value;
    list_start <= first;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // Setup cycle, access cycle, then an idle wait with psel low so back-to-back writes never
  // lower and raise psel in the same step.
  task automatic write_reg(input logic [4:0] addr, input logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, wait for every outstanding result, then let the pipeline settle
  // so a byte that gives no result cannot still be in flight.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (open_runs != 0);
    repeat (8) @(posedge clk);
  endtask

  // One run list: mostly well-formed runs with random content, usually closed by a
  // random terminator; some lists are pure noise or are cut short mid-field.
  task automatic send_random_list();
    int n_runs, pick, len_sz, ofs_sz, cut;
    logic first;
    first = 1'b1;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) begin
        send_byte(8'($urandom), first);
        first = 1'b0;
      end
    end else begin
      n_runs = $urandom_range(0, 10);
      repeat (n_runs) begin
        pick   = $urandom_range(0, 99);
        len_sz = (pick < 70) ? $urandom_range(1, 2) :
                 (pick < 95) ? $urandom_range(3, 4) : $urandom_range(5, 8);
        pick   = $urandom_range(0, 99);
        ofs_sz = (pick < 15) ? 0 : (pick < 75) ? $urandom_range(1, 3) : $urandom_range(4, 8);
        send_byte({4'(ofs_sz), 4'(len_sz)}, first);
        first = 1'b0;
        repeat (len_sz + ofs_sz) send_byte(8'($urandom), 1'b0);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_byte(8'h00, first);
        4: send_byte({4'($urandom_range(0, 15)), 4'h0}, first);
        5: begin
          if ($urandom_range(0, 1) == 1)
            send_byte({4'($urandom_range(0, 15)), 4'($urandom_range(9, 15))}, first);
          else
            send_byte({4'($urandom_range(9, 15)), 4'($urandom_range(1, 15))}, first);
        end
        6: begin
          // open a run and abandon it mid-field; the next list start cuts it off
          len_sz = $urandom_range(1, 8);
          ofs_sz = $urandom_range(0, 8);
          cut    = $urandom_range(0, len_sz + ofs_sz - 1);
          send_byte({4'(ofs_sz), 4'(len_sz)}, first);
          repeat (cut) send_byte(8'($urandom), 1'b0);
        end
        default: ;
      endcase
      // trailing junk, ignored by the block only once the list has ended
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
    end
  endtask

  task automatic run_phase(input logic [63:0] first_vcn, input logic [63:0] last_vcn,
                           input logic [8:0] list_offset, input int items,
                           input logic tx_on, input logic rx_on, input logic long_hold);
    int base;
    write_reg(FIRST_VCN_ADDR, first_vcn);
    write_reg(LAST_VCN_ADDR, last_vcn);
    write_reg(LIST_OFFSET_ADDR, 64'(list_offset));
    tx_jitter = tx_on;
    rx_jitter = rx_on;
    if (long_hold) hold_request = 1'b1;
    base = bytes_sent;
    while (bytes_sent - base < items) send_random_list();
    drain();
  endtask

  // Result sink: ready most of the time, short and occasional long stalls, and a
  // single long hold on request so the block backs up onto its input.
  initial begin : result_sink
    int stall;
    forever begin
      if (hold_request) begin
        stall = LONG_HOLD_CYCLES;
        hold_request = 1'b0;
      end else if (rx_jitter && $urandom_range(0, 99) < 30) begin
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end else begin
        stall = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // End the run if nothing moves on any port for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed lists under reset settings: first_vcn 0, last_vcn 0, budget 448.
    // Header terminators: zero byte, zero length nibble, oversize length, oversize offset.
    send_byte(8'h00, 1'b1);
    send_byte(8'h10, 1'b1);
    send_byte(8'h09, 1'b1);
    send_byte(8'h91, 1'b1);
    // zero-length run with no offset field stays within last_vcn, then a zero header
    send_byte(8'h01, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    // negative one-byte delta, run end past last_vcn, then an ignored byte
    send_byte(8'h11, 1'b1);
    send_byte(8'h05, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hAA, 1'b0);
    // eight-byte length of all ones wraps the vcn to -1, positive delta
    send_byte(8'h18, 1'b1);
    repeat (8) send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    // open a run, then restart the list in the middle of its fields
    send_byte(8'h21, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h00, 1'b1);
    drain();

    // Random phases; each one drains before the next register writes.
    run_phase(64'd0, VCN_MAX, 9'd0, 100, 1'b1, 1'b1, 1'b1);
    run_phase(VCN_MAX, VCN_MAX, 9'($urandom_range(0, 63)), 80, 1'b0, 1'b0, 1'b0);
    run_phase(VCN_MIN, VCN_MIN, 9'd511, 40, 1'b1, 1'b1, 1'b0);
    run_phase({$urandom, $urandom}, {$urandom, $urandom}, 9'd480, 80, 1'b1, 1'b1, 1'b0);
    run_phase(-64'sd1000, 64'sd5000, 9'($urandom_range(300, 511)), 80, 1'b1, 1'b0, 1'b0);
    run_phase(-64'($urandom_range(0, 100000)), VCN_MAX, 9'($urandom_range(0, 511)), 80,
              1'b0, 1'b1, 1'b0);

    @(negedge clk);
    if (fail_count == 0 && open_runs == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

### filelist.f
hdl/erld_pkg.sv
hdl/erld_front.sv
hdl/erld_queue.sv
hdl/erld_back.sv
hdl/extent_run_list_decoder_top.sv
verif/run_list_checker.sv
verif/testbench.sv
